// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/msic_pkg.sv =====
// ----------------------------------------------------------------------------
// msic_pkg
// types, constants and helpers of the multiset intersection counter
// ----------------------------------------------------------------------------
`default_nettype none
package msic_pkg;

   localparam int ENTRIES    = 64;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 16;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_PROBE = 2'd2
   } action_type;

   typedef logic [VALUE_BITS-1:0] key_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [ENTRIES-1:0]    entry_vec_type;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] match_value;
      logic               overflow;
   } rsp_type;

   // operation handed to the table
   typedef struct packed {
      logic       valid;
      action_type action;
      key_type    key;
   } op_type;

   // table outcome for the operation
   typedef struct packed {
      logic match;
      logic overflow;
   } res_type;

   function automatic key_type make_key(logic signed [31:0] v);
      logic [63:0] w;
      w = {32'b0, v};
      return w[VALUE_BITS-1:0];
   endfunction

   function automatic logic signed [31:0] key_to_value(key_type k);
      logic [63:0] w;
      w = 64'(k);
      return w[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/multiset_intersection_counter_core.sv =====
// ----------------------------------------------------------------------------
// multiset_intersection_counter_core
// multiset intersection by occurrence counting over a 64-entry key table
// ----------------------------------------------------------------------------
// usage
//   request: drive req_data with start high; it is taken at an edge where
//   busy is low. busy stays low, so one request can be taken every cycle.
//   clear empties the table, load counts a value of the first set, probe
//   checks a value of the second set and consumes one occurrence on a match.
//   result: a probe that matches gives rsp_valid high for one cycle with the
//   value and the sticky overflow flag; loads, clears and misses give none.
//   timing: the request is held in the request register, passes the parallel
//   compare of all entries and is registered in the result register, which
//   drives the rsp ports. throughput: one request per cycle.
//   results come in request order and cannot be held off by the receiver.
//   a new value that finds the table full is dropped and sets overflow.
//   reset clears the table marks, the overflow flag and all pending work.
// ----------------------------------------------------------------------------
`default_nettype none
module multiset_intersection_counter_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire msic_pkg::req_type req_data,
   output logic                   rsp_valid,
   output msic_pkg::rsp_type      rsp_data
);
   import msic_pkg::*;

   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   op_type  op;
   res_type res;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= res.match;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      op.valid  = req_valid_ff;
      op.action = req_ff.action;
      op.key    = make_key(req_ff.value);
   end

   msic_table u_table (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   always_comb begin
      rsp_in.match_value = key_to_value(op.key);
      rsp_in.overflow    = res.overflow;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/msic_table.sv =====
// ----------------------------------------------------------------------------
// msic_table
// key table with parallel compare, per-entry occurrence counters
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module msic_table (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire msic_pkg::op_type  op,
   output msic_pkg::res_type      res
);
   import msic_pkg::*;

   key_type       key_ff   [ENTRIES];
   count_type     count_ff [ENTRIES];
   entry_vec_type valid_ff, valid_in;
   logic          overflow_ff, overflow_in;

   entry_vec_type hit, count_nz, free_oh, key_we, cnt_inc, cnt_dec;
   logic          any_hit, full, probe_ok;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i]      = valid_ff[i] && (key_ff[i] == op.key);
         count_nz[i] = (count_ff[i] != '0);
      end
   end

   assign any_hit  = |hit;
   assign full     = &valid_ff;
   assign free_oh  = ~valid_ff & (valid_ff + ENTRIES'(1));
   assign probe_ok = |(hit & count_nz);

   always_comb begin
      valid_in     = valid_ff;
      overflow_in  = overflow_ff;
      key_we       = '0;
      cnt_inc      = '0;
      cnt_dec      = '0;
      res.match    = 1'b0;
      res.overflow = overflow_ff;
      if (op.valid) begin
         case (op.action)
            ACT_CLEAR: begin
               valid_in = '0;
            end
            ACT_LOAD: begin
               if (any_hit) begin
                  cnt_inc = hit;
               end else if (!full) begin
                  key_we   = free_oh;
                  valid_in = valid_ff | free_oh;
               end else begin
                  overflow_in = 1'b1;
               end
            end
            ACT_PROBE: begin
               if (probe_ok) begin
                  cnt_dec   = hit;
                  res.match = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         overflow_ff <= overflow_in;
      end
   end

   // per-entry key and counter cells
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (key_we[i]) begin
            key_ff[i]   <= op.key;
            count_ff[i] <= COUNT_BITS'(1);
         end else if (cnt_inc[i] && (count_ff[i] != '1)) begin
            count_ff[i] <= count_ff[i] + COUNT_BITS'(1);
         end else if (cnt_dec[i]) begin
            count_ff[i] <= count_ff[i] - COUNT_BITS'(1);
         end
      end
   end

   `ASSERT_CLK(a_hit_unique, clock, reset, $onehot0(hit), "key held by more than one entry")
   `ASSERT_CLK(a_overflow_sticky, clock, reset, overflow_ff |=> overflow_ff, "overflow dropped")
   `ASSERT_CLK(a_clear_empties, clock, reset,
      (op.valid && op.action == ACT_CLEAR) |=> (valid_ff == '0), "clear left entries valid")
   `ASSERT_CLK(a_match_on_probe, clock, reset,
      res.match |-> (op.valid && op.action == ACT_PROBE && any_hit), "match without probe hit")

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multiset intersection counter core: a table
// model predicts every matching probe, while directed checks and random
// load and probe sessions with idle gaps cover repeated counts, zero-count
// entries, clears and the sticky overflow flag
// ----------------------------------------------------------------------------
module tb_top;
   import msic_pkg::*;

   localparam int         LIMIT_CYCLES = 1_000_000;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         MAX_REPORTS  = 10;
   localparam action_type ACT_IGNORED  = action_type'(2'd3);
   localparam count_type  COUNT_TOP    = '1;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_matches[$];
   logic    req_taken   = 1'b0;
   int      sent_count  = 0;
   int      error_count = 0;
   int      cycle_count = 0;

   // table model
   key_type   tbl_key   [ENTRIES];
   count_type tbl_count [ENTRIES];
   logic      tbl_valid [ENTRIES] = '{default: 1'b0};
   logic      tbl_overflow = 1'b0;

   multiset_intersection_counter_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   task automatic track_request(input req_type r);
      key_type k;
      int      slot;
      logic    placed;
      rsp_type hit;
      k = key_type'($unsigned(r.value));
      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (slot < 0 && tbl_valid[i] && tbl_key[i] == k) slot = i;
      case (r.action)
         ACT_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
         end
         ACT_LOAD: begin
            if (slot >= 0) begin
               if (tbl_count[slot] != COUNT_TOP) tbl_count[slot] = tbl_count[slot] + 1'b1;
            end else begin
               placed = 1'b0;
               for (int i = 0; i < ENTRIES; i++)
                  if (!placed && !tbl_valid[i]) begin
                     tbl_valid[i] = 1'b1;
                     tbl_key[i]   = k;
                     tbl_count[i] = count_type'(1);
                     placed       = 1'b1;
                  end
               if (!placed) tbl_overflow = 1'b1;
            end
         end
         ACT_PROBE: begin
            if (slot >= 0 && tbl_count[slot] != '0) begin
               tbl_count[slot] = tbl_count[slot] - 1'b1;
               hit.match_value = 32'(tbl_key[slot]);
               hit.overflow    = tbl_overflow;
               expected_matches.insert(expected_matches.size(), hit);
            end
         end
         default: ;
      endcase
   endtask

   // request taken and result check, all sampled at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_matches.size() == 0) begin
               flag_error($sformatf("unexpected result: match_value %0d overflow %0b",
                                    rsp_data.match_value, rsp_data.overflow));
            end else begin
               want = expected_matches.pop_front();
               if (rsp_data.match_value !== want.match_value)
                  flag_error($sformatf("match_value mismatch: expected %0d actual %0d",
                                       want.match_value, rsp_data.match_value));
               if (rsp_data.overflow !== want.overflow)
                  flag_error($sformatf("overflow mismatch on %0d: expected %0b actual %0b",
                                       want.match_value, want.overflow, rsp_data.overflow));
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) track_request(req_data);
      end
   end

   // request driver, no idling for a stretch of requests
   always @(negedge clock) begin
      if (!reset && (!start || req_taken)) begin
         if (pending_reqs.size() != 0 &&
             ((sent_count >= 300 && sent_count < 700) || $urandom_range(99) >= 20)) begin
            req_data   <= pending_reqs.pop_front();
            start      <= 1'b1;
            sent_count <= sent_count + 1;
         end else begin
            req_data <= req_type'({2'($urandom_range(3)), 32'($urandom)});
            start    <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic add_req(input action_type a, input logic [31:0] v);
      req_type r;
      r.action = a;
      r.value  = v;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // loads of a random value pool followed by probes, with some noise
   task automatic gen_session(input int pool_size, input bit wipe_first);
      logic [31:0] pool[$];
      for (int i = 0; i < pool_size; i++)
         case ($urandom_range(15))
            0:       pool.insert(pool.size(), 32'h8000_0000);
            1:       pool.insert(pool.size(), 32'h7fff_ffff);
            2:       pool.insert(pool.size(), 32'h0000_0000);
            3:       pool.insert(pool.size(), 32'hffff_ffff);
            default: pool.insert(pool.size(), $urandom);
         endcase
      if (wipe_first) add_req(ACT_CLEAR, $urandom);
      repeat ($urandom_range(1, 3 * pool_size))
         add_req(ACT_LOAD, pool[$urandom_range(pool_size - 1)]);
      repeat ($urandom_range(1, 3 * pool_size))
         case ($urandom_range(19))
            0: add_req(ACT_IGNORED, $urandom);
            1: add_req(ACT_PROBE, $urandom);
            2: add_req(ACT_LOAD, pool[$urandom_range(pool_size - 1)]);
            3: begin
               if ($urandom_range(3) == 0) add_req(ACT_CLEAR, $urandom);
               else add_req(ACT_PROBE, pool[$urandom_range(pool_size - 1)]);
            end
            default: add_req(ACT_PROBE, pool[$urandom_range(pool_size - 1)]);
         endcase
   endtask

   initial begin
      logic [31:0] v;
      int          mark;

      // directed: extremes, every action, zero counts, clear
      add_req(ACT_PROBE, 32'h0000_0000);
      add_req(ACT_IGNORED, 32'hffff_ffff);
      add_req(ACT_LOAD, 32'h8000_0000);
      add_req(ACT_LOAD, 32'h7fff_ffff);
      add_req(ACT_LOAD, 32'h0000_0000);
      add_req(ACT_LOAD, 32'hffff_ffff);
      add_req(ACT_LOAD, 32'hffff_ffff);
      add_req(ACT_PROBE, 32'hffff_ffff);
      add_req(ACT_PROBE, 32'hffff_ffff);
      add_req(ACT_PROBE, 32'hffff_ffff);
      add_req(ACT_PROBE, 32'h7fff_ffff);
      add_req(ACT_PROBE, 32'h8000_0000);
      add_req(ACT_PROBE, 32'h0000_0000);
      add_req(ACT_LOAD, 32'hffff_ffff);
      add_req(ACT_PROBE, 32'hffff_ffff);
      add_req(ACT_IGNORED, 32'h7fff_ffff);
      add_req(ACT_LOAD, 32'h0000_0005);
      add_req(ACT_CLEAR, 32'h0000_0000);
      add_req(ACT_PROBE, 32'h0000_0005);
      add_req(ACT_PROBE, 32'h7fff_ffff);
      add_req(ACT_LOAD, 32'h5555_5555);
      add_req(ACT_LOAD, 32'haaaa_aaaa);
      add_req(ACT_PROBE, 32'haaaa_aaaa);
      add_req(ACT_PROBE, 32'h5555_5555);

      // random sessions while the table cannot fill
      while (pending_reqs.size() < 650) gen_session($urandom_range(1, 20), 1'b1);

      // many occurrences of one value, then drain them
      v = $urandom;
      add_req(ACT_CLEAR, v);
      repeat (40) add_req(ACT_LOAD, v);
      repeat (42) add_req(ACT_PROBE, v);

      // full table, zero-count entry kept, dropped value
      v = $urandom;
      add_req(ACT_CLEAR, v);
      for (int i = 0; i < ENTRIES; i++) add_req(ACT_LOAD, v + i);
      add_req(ACT_PROBE, v);
      add_req(ACT_PROBE, v);
      add_req(ACT_LOAD, v + ENTRIES);
      add_req(ACT_PROBE, v + 1);
      add_req(ACT_PROBE, v + ENTRIES);
      add_req(ACT_CLEAR, v);
      add_req(ACT_LOAD, v + ENTRIES);
      add_req(ACT_PROBE, v + ENTRIES);

      // random sessions with overflow set, table may fill again
      mark = pending_reqs.size();
      while (pending_reqs.size() < mark + 350)
         gen_session($urandom_range(1, 40), 1'($urandom_range(1)));

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_reqs.size() != 0 || start || expected_matches.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
